[hdl/nsr_pkg.sv]
`timescale 1ns / 1ps

package nsr_pkg;

    localparam int DEF_MAX_ITERATIONS = 32;
    localparam int DEF_FRACTION_BITS  = 16;

    localparam int EST_W      = 18;
    localparam int RAD_W      = 20;
    localparam int TOL_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(EST_W);

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GUESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = CFG_IDX_W'(1);

    localparam logic [EST_W-1:0] RST_FIRST_GUESS = EST_W'(131072);
    localparam logic [TOL_W-1:0] RST_TOLERANCE   = TOL_W'(429497);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV_INIT,
        ST_DIV,
        ST_UPDATE,
        ST_CHECK,
        ST_FINISH
    } t_nsr_state;

    typedef struct packed {
        logic load;
        logic square;
        logic div_init;
        logic div_step;
        logic update;
        logic capture;
    } t_nsr_cmd;

    typedef struct packed {
        logic above_tol;
    } t_nsr_status;

endpackage

[hdl/nsr_ctrl.sv]
`timescale 1ns / 1ps

module nsr_ctrl import nsr_pkg::*; #(
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_nsr_status i_status,
    output t_nsr_cmd    o_cmd
);

    localparam int STEP_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [STEP_W-1:0]    MAX_STEPS = STEP_W'(MAX_ITERATIONS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(EST_W - 1);

    t_nsr_state           r_state, n_state;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    t_nsr_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_div_cnt = r_div_cnt;
        cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_steps  = '0;
                    n_state  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                // first pass goes straight to a step: at least one step is always taken
                n_state = (r_steps == '0) ? ST_DIV_INIT : ST_CHECK;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                n_div_cnt    = '0;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                n_steps    = r_steps + 1'b1;
                n_state    = ST_SQUARE;
            end
            ST_CHECK: begin
                if (i_status.above_tol && (r_steps < MAX_STEPS)) begin
                    n_state = ST_DIV_INIT;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && i_out_stall;
        if (cmd.capture) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[hdl/nsr_datapath.sv]
`timescale 1ns / 1ps

module nsr_datapath import nsr_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [RAD_W-1:0]      i_radicand,
    input  logic                  i_last_item,
    input  t_nsr_cmd              i_cmd,
    output t_nsr_status           o_status,
    output logic [EST_W-1:0]      o_root,
    output logic                  o_cap_reached,
    output logic                  o_last_out
);

    localparam int SA_W = RAD_W + FRACTION_BITS;
    localparam int SQ_W = 2 * EST_W;
    // wide enough for x*x + (a << F) and for x << (EST_W + 1)
    localparam int NW   = ((SA_W > SQ_W + 1) ? SA_W : SQ_W + 1) + 1;
    localparam logic [EST_W-1:0] EST_MAX = '1;
    localparam logic [EST_W-1:0] EST_ONE = EST_W'(1);

    logic [EST_W-1:0] r_first_guess;
    logic [TOL_W-1:0] r_tolerance;

    logic [EST_W-1:0] r_x;
    logic [SA_W-1:0]  r_sa;
    logic [SQ_W-1:0]  r_sq;
    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_dsr;
    logic [EST_W-1:0] r_q;
    logic             r_ovf;
    logic             r_last;

    logic [EST_W-1:0] r_root;
    logic             r_cap;
    logic             r_last_out;

    logic [NW-1:0] num;
    logic [NW-1:0] sq_ext;
    logic [NW-1:0] sa_ext;
    logic [NW-1:0] diff;
    logic          above_tol;
    logic          rem_ge;

    assign sq_ext = NW'(r_sq);
    assign sa_ext = NW'(r_sa);
    assign num    = sq_ext + sa_ext;
    assign diff   = sq_ext - sa_ext;
    // an estimate below the root counts as converged
    assign above_tol = (sq_ext > sa_ext) && (diff > NW'(r_tolerance));
    assign rem_ge    = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_guess <= RST_FIRST_GUESS;
            r_tolerance   <= RST_TOLERANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_GUESS: r_first_guess <= i_cfg_data[EST_W-1:0];
                CFG_TOLERANCE:   r_tolerance   <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= (r_first_guess == '0) ? EST_ONE : r_first_guess;
            r_sa   <= SA_W'(i_radicand) << FRACTION_BITS;
            r_last <= i_last_item;
        end
        if (i_cmd.square) begin
            r_sq <= r_x * r_x;
        end
        if (i_cmd.div_init) begin
            // quotient >= 2^EST_W saturates; otherwise EST_W restoring steps suffice
            r_rem <= num;
            r_dsr <= NW'(r_x) << EST_W;
            r_q   <= '0;
            r_ovf <= (num >= (NW'(r_x) << (EST_W + 1)));
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_q   <= {r_q[EST_W-2:0], rem_ge};
            r_dsr <= r_dsr >> 1;
        end
        if (i_cmd.update) begin
            if (r_ovf) begin
                r_x <= EST_MAX;
            end else if (r_q == '0) begin
                r_x <= EST_ONE;
            end else begin
                r_x <= r_q;
            end
        end
        if (i_cmd.capture) begin
            r_root     <= r_x;
            r_cap      <= above_tol;
            r_last_out <= r_last;
        end
    end

    assign o_status.above_tol = above_tol;
    assign o_root             = r_root;
    assign o_cap_reached      = r_cap;
    assign o_last_out         = r_last_out;

endmodule

[hdl/newton_square_root_top.sv]
`timescale 1ns / 1ps
// channel  | handshake                        | payload
// ---------+----------------------------------+----------------------------------
// input    | i_in_valid / o_in_stall          | i_radicand, i_last_item
// output   | o_out_valid / i_out_stall        | o_root, o_cap_reached, o_last_out
// config   | i_cfg_we                         | i_cfg_index, i_cfg_data
//
// One item at a time. Each Newton step is one 18x18 square, then a
// restoring divider that retires one quotient bit per cycle, plus setup,
// update and the tolerance check.
// Synchronous active-low reset clears control and loads the register defaults.
// A finished result waits in the output register; the next item is accepted
// while it waits, and the block only holds in its last state if both are full.

module newton_square_root_top import nsr_pkg::*; #(
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [RAD_W-1:0]      i_radicand,
    input  logic                  i_last_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [EST_W-1:0]      o_root,
    output logic                  o_cap_reached,
    output logic                  o_last_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_nsr_cmd    cmd;
    t_nsr_status status;

    nsr_ctrl #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    nsr_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_radicand    (i_radicand),
        .i_last_item   (i_last_item),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_root        (o_root),
        .o_cap_reached (o_cap_reached),
        .o_last_out    (o_last_out)
    );

endmodule
